// File: rtl/core/tdor_pkg.sv
// ----------------------------------------------------------------------------
// tdor_pkg
// Shared types and constants of the torus dimension-order route walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdor_pkg;

  localparam int NUM_DIMS     = 5;
  localparam int MAX_DIM_SIZE = 8;
  localparam int COORD_W      = 3;
  localparam int SIZE_W       = 4;
  localparam int DIM_W        = 3;
  localparam int HOPCNT_W     = 6;
  localparam int ORDER_W      = 15;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_SIZE_A      = 3'd0;
  localparam logic [2:0] REG_SIZE_B      = 3'd1;
  localparam logic [2:0] REG_SIZE_C      = 3'd2;
  localparam logic [2:0] REG_SIZE_D      = 3'd3;
  localparam logic [2:0] REG_SIZE_E      = 3'd4;
  localparam logic [2:0] REG_WRAP_MASK   = 3'd5;
  localparam logic [2:0] REG_ROUTE_ORDER = 3'd6;

  localparam logic [SIZE_W-1:0]  RST_SIZE_ABCD   = 4'd8;
  localparam logic [SIZE_W-1:0]  RST_SIZE_E      = 4'd2;
  localparam logic [4:0]         RST_WRAP_MASK   = 5'd31;
  localparam logic [ORDER_W-1:0] RST_ROUTE_ORDER = 15'd18056;

  typedef logic [NUM_DIMS-1:0][COORD_W-1:0] coords_t;

  typedef struct packed {
    logic [NUM_DIMS-1:0][SIZE_W-1:0] size;
    logic [NUM_DIMS-1:0]             wrap;
    logic [ORDER_W-1:0]              order;
  } cfg_t;

  typedef struct packed {
    coords_t             hop;
    logic [HOPCNT_W-1:0] hop_number;
    logic [DIM_W-1:0]    moved_dim;
    logic                coord_error;
    logic                last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PLAN,
    ST_LOAD,
    ST_WALK
  } st_t;

  // Sizes above the largest supported dimension are clamped to it.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    eff_size = (s > SIZE_W'(MAX_DIM_SIZE)) ? SIZE_W'(MAX_DIM_SIZE) : s;
  endfunction

endpackage

// File: rtl/core/tdor_cfg_regs.sv
// ----------------------------------------------------------------------------
// tdor_cfg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdor_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [4:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output tdor_pkg::cfg_t cfg
);

  tdor_pkg::cfg_t cfg_r;
  tdor_pkg::cfg_t cfg_nxt;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        tdor_pkg::REG_SIZE_A:      cfg_nxt.size[0] = cfg_pwdata[3:0];
        tdor_pkg::REG_SIZE_B:      cfg_nxt.size[1] = cfg_pwdata[3:0];
        tdor_pkg::REG_SIZE_C:      cfg_nxt.size[2] = cfg_pwdata[3:0];
        tdor_pkg::REG_SIZE_D:      cfg_nxt.size[3] = cfg_pwdata[3:0];
        tdor_pkg::REG_SIZE_E:      cfg_nxt.size[4] = cfg_pwdata[3:0];
        tdor_pkg::REG_WRAP_MASK:   cfg_nxt.wrap    = cfg_pwdata[4:0];
        tdor_pkg::REG_ROUTE_ORDER: cfg_nxt.order   = cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tdor_pkg::REG_SIZE_A:      cfg_prdata = {28'd0, cfg_r.size[0]};
      tdor_pkg::REG_SIZE_B:      cfg_prdata = {28'd0, cfg_r.size[1]};
      tdor_pkg::REG_SIZE_C:      cfg_prdata = {28'd0, cfg_r.size[2]};
      tdor_pkg::REG_SIZE_D:      cfg_prdata = {28'd0, cfg_r.size[3]};
      tdor_pkg::REG_SIZE_E:      cfg_prdata = {28'd0, cfg_r.size[4]};
      tdor_pkg::REG_WRAP_MASK:   cfg_prdata = {27'd0, cfg_r.wrap};
      tdor_pkg::REG_ROUTE_ORDER: cfg_prdata = {17'd0, cfg_r.order};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size[0] <= tdor_pkg::RST_SIZE_ABCD;
      cfg_r.size[1] <= tdor_pkg::RST_SIZE_ABCD;
      cfg_r.size[2] <= tdor_pkg::RST_SIZE_ABCD;
      cfg_r.size[3] <= tdor_pkg::RST_SIZE_ABCD;
      cfg_r.size[4] <= tdor_pkg::RST_SIZE_E;
      cfg_r.wrap    <= tdor_pkg::RST_WRAP_MASK;
      cfg_r.order   <= tdor_pkg::RST_ROUTE_ORDER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/tdor_dist_unit.sv
// ----------------------------------------------------------------------------
// tdor_dist_unit
// Hop count and direction for one dimension, mesh or wrapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdor_dist_unit (
  input  logic [tdor_pkg::COORD_W-1:0] src,
  input  logic [tdor_pkg::COORD_W-1:0] dst,
  input  logic [tdor_pkg::SIZE_W-1:0]  size,
  input  logic                         torus,
  output logic [tdor_pkg::COORD_W-1:0] hops,
  output logic                         plus
);

  logic [tdor_pkg::COORD_W-1:0] diff;
  logic [tdor_pkg::SIZE_W-1:0]  diff2;
  logic [tdor_pkg::SIZE_W-1:0]  wrap_hops;

  assign diff      = (dst > src) ? (dst - src) : (src - dst);
  assign diff2     = {diff, 1'b0};
  assign wrap_hops = size - {1'b0, diff};

  always_comb begin
    hops = diff;
    plus = dst > src;
    if (torus) begin
      priority if (diff2 > size) begin
        hops = wrap_hops[tdor_pkg::COORD_W-1:0];
        plus = !(dst > src);
      end else if (diff2 < size) begin
        plus = !(dst < src);
      end else begin
        // Both ways equally long: an even start coordinate goes plus.
        plus = !src[0];
      end
    end
  end

endmodule

// File: rtl/core/tdor_walker.sv
// ----------------------------------------------------------------------------
// tdor_walker
// Sequencer that checks an item, plans the hops of each order slot with the
// shared distance unit and then steps the walk one hop per cycle while results are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdor_walker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tdor_pkg::cfg_t          cfg,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  tdor_pkg::coords_t       item_src,
  input  tdor_pkg::coords_t       item_dst,
  output logic                    res_valid,
  input  logic                    res_ready,
  output tdor_pkg::res_t          res
);

  localparam int CW = tdor_pkg::COORD_W;
  localparam int ND = tdor_pkg::NUM_DIMS;

  tdor_pkg::st_t st_r, st_nxt;

  tdor_pkg::coords_t             pos_r, pos_nxt;
  tdor_pkg::coords_t             dst_r, dst_nxt;
  logic [2:0]                    k_r, k_nxt;
  logic [ND-1:0]                 seen_r, seen_nxt;
  logic [ND-1:0][CW-1:0]         cnt_r, cnt_nxt;
  logic [ND-1:0]                 dir_r, dir_nxt;
  logic [tdor_pkg::HOPCNT_W-1:0] total_r, total_nxt;
  logic [CW-1:0]                 hops_left_r, hops_left_nxt;
  logic [tdor_pkg::HOPCNT_W-1:0] hops_done_r, hops_done_nxt;
  logic [tdor_pkg::DIM_W-1:0]    cur_dim_r, cur_dim_nxt;
  logic                          cur_plus_r, cur_plus_nxt;

  logic [3:0]                         slot_sh;
  logic [tdor_pkg::DIM_W-1:0]         plan_dim;
  logic [tdor_pkg::DIM_W-1:0]         sel_dim;
  logic                               dim_ok;
  logic [tdor_pkg::DIM_W-1:0]         sel_idx;
  logic [tdor_pkg::SIZE_W-1:0]        sel_size;
  logic [CW-1:0]                      d_hops;
  logic                               d_plus;
  logic [tdor_pkg::SIZE_W-1:0]        pos_ext;
  logic [tdor_pkg::SIZE_W-1:0]        pos_inc;
  logic [tdor_pkg::SIZE_W-1:0]        pos_dec;
  logic [CW-1:0]                      new_coord;
  logic                               coord_err;
  logic                               plan_take;
  logic [tdor_pkg::HOPCNT_W-1:0]      plan_total;
  logic [tdor_pkg::HOPCNT_W-1:0]      hop_num;
  logic                               hop_last;

  // Order slot k sits at bits 3k of the order register.
  assign slot_sh  = {k_r, 1'b0} + {1'b0, k_r};
  assign plan_dim = tdor_pkg::DIM_W'(cfg.order >> slot_sh);
  assign sel_dim  = (st_r == tdor_pkg::ST_WALK) ? cur_dim_r : plan_dim;
  assign dim_ok   = sel_dim < tdor_pkg::DIM_W'(ND);
  assign sel_idx  = dim_ok ? sel_dim : '0;
  assign sel_size = tdor_pkg::eff_size(cfg.size[sel_idx]);

  tdor_dist_unit u_dist (
    .src   (pos_r[sel_idx]),
    .dst   (dst_r[sel_idx]),
    .size  (sel_size),
    .torus (cfg.wrap[sel_idx]),
    .hops  (d_hops),
    .plus  (d_plus)
  );

  // One step along the current dimension, wrapping where the dimension does.
  assign pos_ext = {1'b0, pos_r[sel_idx]};
  assign pos_inc = pos_ext + 4'd1;
  assign pos_dec = pos_ext - 4'd1;

  always_comb begin
    if (cfg.wrap[sel_idx]) begin
      if (cur_plus_r) begin
        new_coord = (pos_inc == sel_size) ? '0 : pos_inc[CW-1:0];
      end else begin
        new_coord = (pos_ext == '0) ? CW'(sel_size - 4'd1) : pos_dec[CW-1:0];
      end
    end else begin
      new_coord = cur_plus_r ? pos_inc[CW-1:0] : pos_dec[CW-1:0];
    end
  end

  always_comb begin
    coord_err = 1'b0;
    for (int d = 0; d < ND; d++) begin
      if ({1'b0, pos_r[d]} >= tdor_pkg::eff_size(cfg.size[d]) ||
          {1'b0, dst_r[d]} >= tdor_pkg::eff_size(cfg.size[d])) begin
        coord_err = 1'b1;
      end
    end
  end

  // A dimension already walked sits at its destination, so a repeat gives no hops.
  assign plan_take  = dim_ok && !seen_r[sel_idx];
  assign plan_total = plan_take ? total_r + {3'd0, d_hops} : total_r;
  assign hop_num    = hops_done_r + 6'd1;
  assign hop_last   = hop_num == total_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      tdor_pkg::ST_IDLE: begin
        if (item_valid) st_nxt = tdor_pkg::ST_CHECK;
      end
      tdor_pkg::ST_CHECK: begin
        if (!coord_err) st_nxt = tdor_pkg::ST_PLAN;
        else if (res_ready) st_nxt = tdor_pkg::ST_IDLE;
      end
      tdor_pkg::ST_PLAN: begin
        if (k_r == 3'(ND - 1)) begin
          st_nxt = (plan_total == '0) ? tdor_pkg::ST_IDLE : tdor_pkg::ST_LOAD;
        end
      end
      tdor_pkg::ST_LOAD: begin
        st_nxt = tdor_pkg::ST_WALK;
      end
      tdor_pkg::ST_WALK: begin
        if (hops_left_r == '0) st_nxt = tdor_pkg::ST_LOAD;
        else if (res_ready && hop_last) st_nxt = tdor_pkg::ST_IDLE;
      end
      default: st_nxt = tdor_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    dst_nxt       = dst_r;
    k_nxt         = k_r;
    seen_nxt      = seen_r;
    cnt_nxt       = cnt_r;
    dir_nxt       = dir_r;
    total_nxt     = total_r;
    hops_left_nxt = hops_left_r;
    hops_done_nxt = hops_done_r;
    cur_dim_nxt   = cur_dim_r;
    cur_plus_nxt  = cur_plus_r;
    item_ready    = 1'b0;
    res_valid     = 1'b0;
    res           = '0;
    unique case (st_r)
      tdor_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          pos_nxt = item_src;
          dst_nxt = item_dst;
        end
      end
      tdor_pkg::ST_CHECK: begin
        k_nxt         = '0;
        seen_nxt      = '0;
        total_nxt     = '0;
        hops_done_nxt = '0;
        if (coord_err) begin
          res_valid       = 1'b1;
          res.coord_error = 1'b1;
          res.last        = 1'b1;
        end
      end
      tdor_pkg::ST_PLAN: begin
        cnt_nxt[k_r] = plan_take ? d_hops : '0;
        dir_nxt[k_r] = d_plus;
        total_nxt    = plan_total;
        if (plan_take) seen_nxt[sel_idx] = 1'b1;
        k_nxt = (k_r == 3'(ND - 1)) ? '0 : k_r + 3'd1;
      end
      tdor_pkg::ST_LOAD: begin
        hops_left_nxt = cnt_r[k_r];
        cur_dim_nxt   = plan_dim;
        cur_plus_nxt  = dir_r[k_r];
        k_nxt         = k_r + 3'd1;
      end
      tdor_pkg::ST_WALK: begin
        if (hops_left_r != '0) begin
          res_valid          = 1'b1;
          res.hop            = pos_r;
          res.hop[sel_idx]   = new_coord;
          res.hop_number     = hop_num;
          res.moved_dim      = cur_dim_r;
          res.last           = hop_last;
          if (res_ready) begin
            pos_nxt[sel_idx] = new_coord;
            hops_left_nxt    = hops_left_r - 3'd1;
            hops_done_nxt    = hop_num;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tdor_pkg::ST_IDLE;
      k_r         <= '0;
      seen_r      <= '0;
      total_r     <= '0;
      hops_left_r <= '0;
      hops_done_r <= '0;
    end else begin
      st_r        <= st_nxt;
      k_r         <= k_nxt;
      seen_r      <= seen_nxt;
      total_r     <= total_nxt;
      hops_left_r <= hops_left_nxt;
      hops_done_r <= hops_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    dst_r      <= dst_nxt;
    cnt_r      <= cnt_nxt;
    dir_r      <= dir_nxt;
    cur_dim_r  <= cur_dim_nxt;
    cur_plus_r <= cur_plus_nxt;
  end

endmodule

// File: rtl/core/torus_dimension_order_route_walk_core.sv
// ----------------------------------------------------------------------------
// torus_dimension_order_route_walk_core
// Dimension-order route walk through a five-dimensional torus or mesh.
// ----------------------------------------------------------------------------
// One input item (source and destination coordinates) yields one result item
// per hop, walking the dimensions in the configured order, with tlast on the
// final hop; identical coordinates yield nothing and an out-of-range
// coordinate yields a single error item. The block takes one item at a time
// and is not ready until the walk is done. An item is accepted, range-checked,
// then planned one order slot at a time through the shared distance unit over
// all five slots; each order slot reached is then loaded and its hops stepped
// one by one, and the walk stalls whenever the result channel stalls.
// Configuration must be written only while idle; the block itself does not
// enforce it.
`timescale 1ns / 1ps

module torus_dimension_order_route_walk_core (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0: src_a, src_b, src_c, src_d, src_e,
  //                       dst_a, dst_b, dst_c, dst_d, dst_e, zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out_tdata, from bit 0: hop_a, hop_b, hop_c, hop_d, hop_e, hop_number,
  //                        moved_dim
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // out_tuser, from bit 0: coord_error
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tdor_pkg::cfg_t    cfg;
  tdor_pkg::res_t    res;
  logic              res_valid;
  logic              res_ready;
  tdor_pkg::coords_t item_src;
  tdor_pkg::coords_t item_dst;

  logic              out_valid_r;
  logic [23:0]       out_data_r;
  logic              out_err_r;
  logic              out_last_r;

  assign item_src = in_tdata[14:0];
  assign item_dst = in_tdata[29:15];

  tdor_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tdor_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_src   (item_src),
    .item_dst   (item_dst),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: a new result loads as the previous one is taken.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {res.moved_dim, res.hop_number, res.hop};
      out_err_r  <= res.coord_error;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_err_r;
  assign out_tlast    = out_last_r;

endmodule

// File: sim/route_walk_checker.sv
// ----------------------------------------------------------------------------
// route_walk_checker
// Watches the route walker's ports, predicts every hop item and compares.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the size, wrap and order registers by
// snooping writes on the configuration port. For each accepted route request
// it walks the dimensions itself and queues the expected hop items. Each
// accepted hop item is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module route_walk_checker
  import tdor_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          hops_owed,
  output int          routes_seen,
  output int          hops_seen,
  output int          error_items
);

  logic [SIZE_W-1:0]  node_count [NUM_DIMS];
  logic [NUM_DIMS-1:0] wrap_dims;
  logic [ORDER_W-1:0] dim_order;
  res_t               pending_hops [$];
  res_t               got;
  res_t               want;
  logic [2:0]         reg_index;

  // Queues every hop of one request. An item is held back by one hop so that
  // the final one can be marked as the last.
  function automatic void walk_route(input coords_t src, input coords_t dst);
    coords_t          pos;
    int               lim [NUM_DIMS];
    int               span, here, goal, gap, steps;
    logic [DIM_W-1:0] dim;
    logic             bad, torus, up, held;
    res_t             hop_item;
    pos      = src;
    bad      = 1'b0;
    held     = 1'b0;
    hop_item = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lim[d] = (node_count[d] > MAX_DIM_SIZE) ? MAX_DIM_SIZE : int'(node_count[d]);
      if (src[d] >= lim[d] || dst[d] >= lim[d]) bad = 1'b1;
    end
    if (bad) begin
      hop_item.coord_error = 1'b1;
      hop_item.last        = 1'b1;
      pending_hops.push_back(hop_item);
      return;
    end
    for (int k = 0; k < NUM_DIMS; k++) begin
      dim = dim_order[3*k +: 3];
      if (dim < NUM_DIMS) begin
        span  = lim[dim];
        here  = pos[dim];
        goal  = dst[dim];
        gap   = (goal > here) ? goal - here : here - goal;
        torus = wrap_dims[dim];
        steps = gap;
        up    = goal > here;
        if (torus) begin
          if (2 * gap > span) begin
            steps = span - gap;
            up    = !(goal > here);
          end else if (2 * gap < span) begin
            up = !(goal < here);
          end else begin
            // Both ways are equally long: the parity of the start decides.
            up = (here % 2) == 0;
          end
        end
        repeat (steps) begin
          if (torus) here = up ? (here + 1) % span : (here + span - 1) % span;
          else       here = up ? here + 1 : here - 1;
          pos[dim] = COORD_W'(here);
          if (held) pending_hops.push_back(hop_item);
          hop_item.hop        = pos;
          hop_item.hop_number = hop_item.hop_number + 1'b1;
          hop_item.moved_dim  = dim;
          held                = 1'b1;
        end
      end
    end
    if (held) begin
      hop_item.last = 1'b1;
      pending_hops.push_back(hop_item);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        node_count[d] = (d == NUM_DIMS - 1) ? RST_SIZE_E : RST_SIZE_ABCD;
      end
      wrap_dims = RST_WRAP_MASK;
      dim_order = RST_ROUTE_ORDER;
      pending_hops.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        reg_index = cfg_paddr[4:2];
        if (reg_index <= REG_SIZE_E)              node_count[reg_index] = cfg_pwdata[SIZE_W-1:0];
        else if (reg_index == REG_WRAP_MASK)      wrap_dims = cfg_pwdata[NUM_DIMS-1:0];
        else if (reg_index == REG_ROUTE_ORDER)    dim_order = cfg_pwdata[ORDER_W-1:0];
      end
      // Hop items are checked before a new request is queued, since any item
      // seen in the same cycle belongs to an older request.
      if (out_tvalid && out_tready) begin
        got.hop         = out_tdata[14:0];
        got.hop_number  = out_tdata[20:15];
        got.moved_dim   = out_tdata[23:21];
        got.coord_error = out_tuser[0];
        got.last        = out_tlast;
        hops_seen++;
        if (got.coord_error) error_items++;
        if (pending_hops.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected hop item: hop=%o num=%0d dim=%0d err=%0d last=%0d",
                     $realtime, got.hop, got.hop_number, got.moved_dim, got.coord_error,
                     got.last);
          end
        end else begin
          want = pending_hops.pop_front();
          if (want.hop != got.hop || want.hop_number != got.hop_number ||
              want.moved_dim != got.moved_dim || want.coord_error != got.coord_error ||
              want.last != got.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: hop mismatch: expected hop=%o num=%0d dim=%0d err=%0d last=%0d",
                       $realtime, want.hop, want.hop_number, want.moved_dim,
                       want.coord_error, want.last);
              $display("%0t:                  got hop=%o num=%0d dim=%0d err=%0d last=%0d",
                       $realtime, got.hop, got.hop_number, got.moved_dim,
                       got.coord_error, got.last);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        routes_seen++;
        walk_route(in_tdata[14:0], in_tdata[29:15]);
      end
    end
    hops_owed = pending_hops.size();
  end

endmodule

// File: sim/torus_dimension_order_route_walk_core_test.sv
// ----------------------------------------------------------------------------
// torus_dimension_order_route_walk_core_test
// Stimulus and verdict for the torus dimension-order route walker.
// ----------------------------------------------------------------------------
// Directed routes cover ties on even and odd starts, the short way round,
// full mesh walks, range errors, clamped and zero sizes, skipped and repeated
// order entries. Random routes then run under several random register
// settings, with random gaps on both channels and one phase without any.
// The checker beside the block predicts and compares every hop item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module torus_dimension_order_route_walk_core_test;
  import tdor_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 6;
  localparam int PHASE_ROUTES = 20;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [31:0] in_tdata    = '0;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic calm = 1'b0;
  logic [NUM_DIMS-1:0][SIZE_W-1:0] size_now =
    {RST_SIZE_E, RST_SIZE_ABCD, RST_SIZE_ABCD, RST_SIZE_ABCD, RST_SIZE_ABCD};
  int settings_used = 1;
  int quiet = 0;
  int fail_count, hops_owed, routes_seen, hops_seen, error_items;

  always #10 clk = ~clk;

  torus_dimension_order_route_walk_core dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  route_walk_checker walk_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .hops_owed, .routes_seen, .hops_seen, .error_items
  );

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, QUIET_LIMIT);
      $display("torus_dimension_order_route_walk_core_test: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic coords_t node(input int a, input int b, input int c, input int d,
                                   input int e);
    return {COORD_W'(e), COORD_W'(d), COORD_W'(c), COORD_W'(b), COORD_W'(a)};
  endfunction

  function automatic coords_t pick_coords();
    coords_t           c;
    logic [SIZE_W-1:0] lim;
    for (int d = 0; d < NUM_DIMS; d++) begin
      lim  = eff_size(size_now[d]);
      c[d] = (lim == 0) ? COORD_W'($urandom_range(7)) : COORD_W'($urandom_range(lim - 1));
    end
    return c;
  endfunction

  task automatic send_route(input coords_t src, input coords_t dst);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, dst, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drops valid, waits for every owed hop, then lets a request that gives no
  // hop item finish its walk as well.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (hops_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic load_setting(input cfg_t c);
    wait_idle();
    for (int d = 0; d < NUM_DIMS; d++) write_reg(REG_SIZE_A + 3'(d), 32'(c.size[d]));
    write_reg(REG_WRAP_MASK, 32'(c.wrap));
    write_reg(REG_ROUTE_ORDER, 32'(c.order));
    size_now = c.size;
    settings_used++;
  endtask

  initial begin
    cfg_t    setting;
    coords_t src, dst;
    int      order_slot [NUM_DIMS];
    int      pick, tmp, roll, d;
    logic [SIZE_W-1:0] lim;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: all dimensions wrap, E has two nodes, order A to E.
    send_route(node(0, 0, 0, 0, 0), node(0, 0, 0, 0, 0));
    send_route(node(0, 0, 0, 0, 0), node(4, 4, 4, 4, 1));
    send_route(node(1, 3, 5, 7, 1), node(5, 7, 1, 3, 0));
    send_route(node(0, 0, 0, 0, 0), node(7, 7, 7, 7, 1));
    send_route(node(7, 7, 7, 7, 1), node(0, 0, 0, 0, 0));
    send_route(node(0, 0, 0, 0, 2), node(0, 0, 0, 0, 0));
    send_route(node(3, 3, 3, 3, 0), node(3, 3, 3, 3, 7));

    // Plain mesh walked from E back to A: the longest walks.
    setting.size  = {5{4'd8}};
    setting.wrap  = 5'b00000;
    setting.order = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
    load_setting(setting);
    send_route(node(0, 0, 0, 0, 0), node(7, 7, 7, 7, 7));
    send_route(node(7, 7, 7, 7, 7), node(0, 0, 0, 0, 0));
    send_route(node(7, 7, 7, 7, 7), node(7, 7, 7, 7, 7));

    // One-node A, clamped B and C, odd E; order E, skip, E again, C, skip.
    setting.size  = {4'd3, 4'd5, 4'd9, 4'd15, 4'd1};
    setting.wrap  = 5'b10101;
    setting.order = {3'd5, 3'd2, 3'd4, 3'd7, 3'd4};
    load_setting(setting);
    send_route(node(0, 7, 0, 1, 0), node(0, 0, 7, 4, 2));
    send_route(node(0, 3, 6, 4, 1), node(0, 5, 1, 0, 0));
    send_route(node(1, 0, 0, 0, 0), node(0, 0, 0, 0, 0));
    send_route(node(0, 0, 0, 5, 0), node(0, 1, 2, 3, 1));

    // A zero size rejects every request; an order of only skips walks nothing.
    setting.size  = {4'd8, 4'd8, 4'd0, 4'd8, 4'd8};
    setting.wrap  = 5'b11111;
    setting.order = {5{3'd7}};
    load_setting(setting);
    send_route(node(0, 0, 0, 0, 0), node(0, 0, 0, 0, 0));
    setting.size  = {5{4'd8}};
    load_setting(setting);
    send_route(node(0, 0, 0, 0, 0), node(5, 5, 5, 5, 5));

    for (int phase = 0; phase < PHASES; phase++) begin
      for (int k = 0; k < NUM_DIMS; k++) begin
        setting.size[k] = ($urandom_range(11) == 0) ? SIZE_W'($urandom_range(15))
                                                    : SIZE_W'($urandom_range(8, 1));
        order_slot[k] = k;
      end
      setting.wrap = NUM_DIMS'($urandom_range(31));
      for (int k = NUM_DIMS - 1; k > 0; k--) begin
        pick = $urandom_range(k);
        tmp = order_slot[k];
        order_slot[k] = order_slot[pick];
        order_slot[pick] = tmp;
      end
      for (int k = 0; k < NUM_DIMS; k++) setting.order[3*k +: 3] = DIM_W'(order_slot[k]);
      if ($urandom_range(4) == 0) setting.order = ORDER_W'($urandom_range(32767));
      // The all-zero order names dimension A in every slot; only the first walks it.
      if (phase == 0) setting.order = '0;
      if (phase == 1) setting.size = {5{4'd8}};
      load_setting(setting);
      calm = (phase == 1);
      for (int n = 0; n < PHASE_ROUTES; n++) begin
        src  = pick_coords();
        dst  = pick_coords();
        roll = $urandom_range(99);
        if (roll < 6) begin
          dst = src;
        end else if (roll < 16) begin
          d   = $urandom_range(NUM_DIMS - 1);
          lim = eff_size(size_now[d]);
          if (lim < MAX_DIM_SIZE) begin
            if ($urandom_range(1)) src[d] = COORD_W'($urandom_range(7, lim));
            else                   dst[d] = COORD_W'($urandom_range(7, lim));
          end
        end
        send_route(src, dst);
      end
      calm = 1'b0;
    end

    wait_idle();
    $display("Covered %0d route requests under %0d register settings.",
             routes_seen, settings_used);
    $display("Checked %0d hop items, %0d of them range errors.", hops_seen, error_items);
    if (fail_count == 0 && hops_owed == 0) begin
      $display("torus_dimension_order_route_walk_core_test: PASS");
    end else begin
      $display("%0d mismatches, %0d hop items never arrived", fail_count, hops_owed);
      $display("torus_dimension_order_route_walk_core_test: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tdor_pkg.sv
rtl/core/tdor_cfg_regs.sv
rtl/core/tdor_dist_unit.sv
rtl/core/tdor_walker.sv
rtl/core/torus_dimension_order_route_walk_core.sv
sim/route_walk_checker.sv
sim/torus_dimension_order_route_walk_core_test.sv
